// ===== rtl/fft_size_round_up_235_core_assert.svh =====
// Assertion macros for the 5-smooth length rounding core.
`ifndef FFT_SIZE_ROUND_UP_235_CORE_ASSERT_SVH
`define FFT_SIZE_ROUND_UP_235_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define FSRU_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`define FSRU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define FSRU_ASSERT_IMPL(lbl, ante, cons, msg)
`define FSRU_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== rtl/fsru_pkg.sv =====
// Shared types, constants and command codes of the 5-smooth length rounding core.
`timescale 1ns / 1ps
`default_nettype none
package fsru_pkg;

  localparam int unsigned LEN_W = 13;

  typedef logic [LEN_W-1:0] len_t;

  localparam len_t LEN_MAX = {LEN_W{1'b1}};

  // Inverse of an odd constant modulo 2**LEN_W by Newton iteration; elaboration only.
  function automatic len_t inv_mod(input len_t d);
    len_t inv;
    inv = d;
    for (int i = 0; i < 5; i++) begin
      inv = len_t'(inv * len_t'(len_t'(2) - len_t'(d * inv)));
    end
    return inv;
  endfunction

  localparam len_t INV3 = inv_mod(len_t'(3));
  localparam len_t INV5 = inv_mod(len_t'(5));
  // A product with the inverse at or below these limits is the exact quotient.
  localparam len_t LIM3 = len_t'(LEN_MAX / 3);
  localparam len_t LIM5 = len_t'(LEN_MAX / 5);

  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_STRIP,
    CMD_NEXT,
    CMD_FOUND,
    CMD_OVF
  } dp_cmd_e;

  typedef struct packed {
    logic has_factor;
    logic cof_one;
    logic trial_max;
  } dp_status_t;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } ctrl_state_e;

endpackage
`default_nettype wire

// ===== rtl/fsru_dp.sv =====
// Datapath: trial value, cofactor stripping by 2, 3 and 5, and the result register.
`timescale 1ns / 1ps
`default_nettype none
module fsru_dp (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire fsru_pkg::len_t   requested_length_i,
  input  wire fsru_pkg::dp_cmd_e cmd_i,
  output fsru_pkg::dp_status_t  status_o,
  output fsru_pkg::len_t        smooth_length_o
);
  import fsru_pkg::*;

  len_t trial_q, trial_d;
  len_t cof_q, cof_d;
  len_t result_q, result_d;
  len_t q3, q5;
  logic div3, div5;

  // Multiplying by the modular inverse gives the quotient when the division is exact.
  assign q3   = len_t'(cof_q * INV3);
  assign q5   = len_t'(cof_q * INV5);
  assign div3 = (q3 <= LIM3);
  assign div5 = (q5 <= LIM5);

  // Fields in declaration order: has_factor, cof_one, trial_max.
  assign status_o = {~cof_q[0] | div3 | div5,
                     cof_q == len_t'(1),
                     trial_q == LEN_MAX};

  always_comb begin
    trial_d  = trial_q;
    cof_d    = cof_q;
    result_d = result_q;
    case (cmd_i)
      CMD_LOAD: begin
        trial_d = (requested_length_i == '0) ? len_t'(1) : requested_length_i;
        cof_d   = trial_d;
      end
      CMD_STRIP: begin
        if (!cof_q[0]) begin
          cof_d = {1'b0, cof_q[LEN_W-1:1]};
        end else if (div3) begin
          cof_d = q3;
        end else begin
          cof_d = q5;
        end
      end
      CMD_NEXT: begin
        trial_d = trial_q + len_t'(1);
        cof_d   = trial_d;
      end
      CMD_FOUND: result_d = trial_q;
      CMD_OVF:   result_d = '0;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trial_q  <= '0;
      cof_q    <= '0;
      result_q <= '0;
    end else begin
      trial_q  <= trial_d;
      cof_q    <= cof_d;
      result_q <= result_d;
    end
  end

  assign smooth_length_o = result_q;

endmodule
`default_nettype wire

// ===== rtl/fsru_ctrl.sv =====
// Controller: sequences load, strip and next-trial steps and raises the result strobe.
`timescale 1ns / 1ps
`default_nettype none
module fsru_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start,
  input  wire fsru_pkg::dp_status_t status_i,
  output fsru_pkg::dp_cmd_e       cmd_o,
  output logic                    busy,
  output logic                    result_valid_o
);
  import fsru_pkg::*;

  ctrl_state_e state_q, state_d;
  logic done_q, done_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = CMD_NONE;
    done_d  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          cmd_o   = CMD_LOAD;
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        // Strip one factor per cycle; once none divides, judge the trial.
        if (status_i.has_factor) begin
          cmd_o = CMD_STRIP;
        end else if (status_i.cof_one) begin
          cmd_o   = CMD_FOUND;
          done_d  = 1'b1;
          state_d = ST_IDLE;
        end else if (status_i.trial_max) begin
          cmd_o   = CMD_OVF;
          done_d  = 1'b1;
          state_d = ST_IDLE;
        end else begin
          cmd_o = CMD_NEXT;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign busy           = (state_q != ST_IDLE);
  assign result_valid_o = done_q;

endmodule
`default_nettype wire

// ===== rtl/fft_size_round_up_235_core.sv =====
// After the accepting edge the core strips factors of 2, 3 and 5 from the trial, checks it
// and steps on until a trial is 5-smooth or the maximum, then raises the strobe; a request
// of 6913 runs trials up to 7200. One item at a time, with a run time set by the gap to the
// next 5-smooth value; busy falls as the strobe rises, so a new transfer may share the
// result's edge. Reset (rst_ni low, asynchronous) idles the controller and clears the
// datapath and the strobe. The receiver cannot stall: each result shows for one cycle.
`timescale 1ns / 1ps
`default_nettype none
`include "fft_size_round_up_235_core_assert.svh"
module fft_size_round_up_235_core (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start,
  output logic                busy,
  input  wire fsru_pkg::len_t requested_length_i,
  output logic                result_valid_o,
  output fsru_pkg::len_t      smooth_length_o
);
  import fsru_pkg::*;

  dp_cmd_e    cmd;
  dp_status_t status;

  fsru_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .status_i       (status),
    .cmd_o          (cmd),
    .busy           (busy),
    .result_valid_o (result_valid_o)
  );

  fsru_dp u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .requested_length_i (requested_length_i),
    .cmd_i              (cmd),
    .status_o           (status),
    .smooth_length_o    (smooth_length_o)
  );

  `FSRU_ASSERT_NEXT(a_accept_sets_busy, start && !busy, busy, "busy not set after transfer")
  `FSRU_ASSERT_NEXT(a_strobe_single, result_valid_o, !result_valid_o, "result strobe held")
  `FSRU_ASSERT_IMPL(a_strobe_idle, result_valid_o, !busy, "result strobe while busy")
  `FSRU_ASSERT_NEXT(a_finish_strobe, busy && (cmd == CMD_FOUND || cmd == CMD_OVF),
                    result_valid_o, "finish without result strobe")

endmodule
`default_nettype wire

// ===== dv/tb_fft_size_round_up_235_core.sv =====
// Self-checking testbench for the 5-smooth length rounding core.
`timescale 1ns / 1ps
`default_nettype none
module tb_fft_size_round_up_235_core;
  import fsru_pkg::*;

  typedef struct {
    len_t        length;
    int unsigned idle_after;
    logic        drain_first;
  } length_req_t;

  localparam int unsigned RANDOM_ITEMS = 1400;
  localparam int unsigned QUIET_TAIL   = 150;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  len_t requested_length_i = '0;
  logic busy;
  logic result_valid_o;
  len_t smooth_length_o;

  length_req_t req_q[$];
  len_t        smooth_len_q[$];
  logic        took_item = 1'b0;
  logic        stim_done = 1'b0;
  int unsigned gap_left = 0;
  int unsigned err_count = 0;
  int unsigned n_taken = 0;
  int unsigned n_results = 0;
  int unsigned n_zero_req = 0;
  int unsigned n_overflow = 0;

  fft_size_round_up_235_core dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start              (start),
    .busy               (busy),
    .requested_length_i (requested_length_i),
    .result_valid_o     (result_valid_o),
    .smooth_length_o    (smooth_length_o)
  );

  always #6 clk_i = ~clk_i;

  // Smallest value at or above the request whose only prime factors are 2, 3 and 5;
  // zero when that value does not fit in the length width.
  function automatic len_t next_smooth_length(len_t req);
    int unsigned trial;
    int unsigned cof;
    trial = (req == '0) ? 1 : int'(req);
    while (trial <= int'(LEN_MAX)) begin
      cof = trial;
      while (cof % 2 == 0) cof = cof / 2;
      while (cof % 3 == 0) cof = cof / 3;
      while (cof % 5 == 0) cof = cof / 5;
      if (cof == 1) return len_t'(trial);
      trial++;
    end
    return '0;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    err_count++;
  endtask

  task automatic add_req(input len_t length, input int unsigned idle_after,
                         input logic drain_first);
    length_req_t r;
    r.length      = length;
    r.idle_after  = idle_after;
    r.drain_first = drain_first;
    req_q.push_back(r);
  endtask

  function automatic int unsigned pick_idle();
    if ($urandom_range(2) == 0) return $urandom_range(1, 15);
    return 0;
  endfunction

  function automatic len_t pick_length();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 45) return len_t'($urandom_range(1, 4096));
    if (sel < 65) return len_t'($urandom_range(0, 64));
    if (sel < 90) return len_t'($urandom);
    return len_t'($urandom_range(8090, int'(LEN_MAX)));
  endfunction

  // Driver: one nonblocking update of start and the request per falling edge.
  always @(negedge clk_i) begin : drive_proc
    length_req_t item;
    logic        next_start;
    len_t        next_len;
    next_start = start;
    next_len   = requested_length_i;
    if (rst_ni) begin
      if (start && took_item) begin
        next_start = 1'b0;
        next_len   = len_t'($urandom);
      end
      if (!next_start) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (req_q.size() > 0) begin
          if (!(req_q[0].drain_first && smooth_len_q.size() != 0)) begin
            item       = req_q.pop_front();
            next_start = 1'b1;
            next_len   = item.length;
            gap_left   = item.idle_after;
          end
        end else begin
          stim_done = 1'b1;
        end
      end
      start              <= next_start;
      requested_length_i <= next_len;
    end
  end

  // Monitor: results are checked before the transfer at the same edge is queued.
  always @(posedge clk_i) begin : monitor_proc
    len_t want;
    took_item <= rst_ni && start && !busy;
    if (rst_ni) begin
      if (result_valid_o) begin
        n_results++;
        if (smooth_len_q.size() == 0) begin
          report_mismatch($sformatf("result %0d with no request outstanding",
                                    smooth_length_o));
        end else begin
          want = smooth_len_q.pop_front();
          if (smooth_length_o !== want)
            report_mismatch($sformatf("smooth_length got %0d, expected %0d",
                                      smooth_length_o, want));
        end
      end
      if (start && !busy) begin
        want = next_smooth_length(requested_length_i);
        smooth_len_q.push_back(want);
        n_taken++;
        if (requested_length_i == '0) n_zero_req++;
        if (want == '0) n_overflow++;
      end
    end
  end

  initial begin
    int unsigned tail_wait;
    // Directed part: field extremes, zero request, overflow band and its edge.
    add_req(len_t'(0), 0, 1'b0);
    add_req(len_t'(1), 0, 1'b0);
    add_req(len_t'(2), 3, 1'b0);
    add_req(len_t'(7), 0, 1'b0);
    add_req(len_t'(11), 0, 1'b0);
    add_req(len_t'(97), 1, 1'b0);
    add_req(len_t'(4095), 0, 1'b0);
    add_req(len_t'(4096), 0, 1'b0);
    add_req(len_t'(4097), 5, 1'b0);
    add_req(len_t'(7777), 0, 1'b0);
    add_req(len_t'(8000), 0, 1'b0);
    add_req(len_t'(8001), 0, 1'b1);
    add_req(len_t'(8100), 0, 1'b0);
    add_req(len_t'(8101), 2, 1'b0);
    add_req(len_t'(8190), 0, 1'b0);
    add_req(LEN_MAX, 0, 1'b0);
    add_req(len_t'(13'h1555), 0, 1'b0);
    add_req(len_t'(13'h0AAA), 0, 1'b1);
    add_req(len_t'(0), 0, 1'b0);
    add_req(len_t'(3), 0, 1'b0);
    add_req(len_t'(5), 0, 1'b0);
    for (int unsigned i = 0; i < RANDOM_ITEMS; i++) begin
      add_req(pick_length(), (i < RANDOM_ITEMS - QUIET_TAIL) ? pick_idle() : 0,
              (i % 300) == 150);
    end

    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;

    while (!stim_done) @(posedge clk_i);
    while (smooth_len_q.size() != 0) @(posedge clk_i);
    // A late or duplicate strobe would show up during this wait.
    for (tail_wait = 0; tail_wait < 64; tail_wait++) @(posedge clk_i);

    if (smooth_len_q.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", smooth_len_q.size()));
    $display("Rounded %0d requested lengths (%0d zero requests, %0d past the width).",
             n_taken, n_zero_req, n_overflow);
    $display("Checked %0d result strobes with random sender gaps and drain pauses.",
             n_results);
    if (err_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #100_000_000;
    $display("Timeout: run did not complete.");
    $display("*** FAILED ***");
    $finish;
  end

endmodule
`default_nettype wire

// ===== filelist.f =====
+incdir+rtl
rtl/fsru_pkg.sv
rtl/fsru_dp.sv
rtl/fsru_ctrl.sv
rtl/fft_size_round_up_235_core.sv
dv/tb_fft_size_round_up_235_core.sv
